### design/bbs_pkg.sv
// shared types, widths and codes for the bollinger band signal unit
// no dependencies; imported by the top level and the checker
package bbs_pkg;

  // field and state widths
  localparam int PRICE_W   = 24;
  localparam int WIN_MAX   = 256;
  localparam int PTR_W     = $clog2(WIN_MAX);
  localparam int LEN_W     = 9;
  localparam int MULT_W    = 12;
  localparam int SUM_W     = 32;
  localparam int SQ_W      = 56;
  localparam int IDX_W     = 32;
  localparam int MEAN_W    = 32;
  localparam int UPPER_W   = 37;
  localparam int LOWER_W   = 38;
  localparam int ACT_W     = 2;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // shared datapath widths
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 64;
  localparam int Q_SPLIT = 28;
  localparam int REM_W   = 17;
  localparam int SD_W    = 32;
  localparam int BAND_W  = 36;
  localparam int CNT_W   = 5;

  // iteration counts, loaded as last-step index
  localparam logic [CNT_W-1:0] DIV_MEAN_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_VAR_LAST  = 5'd31;
  localparam logic [CNT_W-1:0] SQRT_LAST     = 5'd31;
  localparam logic [PROD_W-1:0] SQRT_BIT0    = 64'h4000_0000_0000_0000;

  // register reset values
  localparam logic [LEN_W-1:0]  WIN_LEN_RST = 9'd20;
  localparam logic [MULT_W-1:0] MULT_RST    = 12'd512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD = 2'd0,
    ACT_SELL = 2'd1,
    ACT_BUY  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD,
    S_NEWSQ,
    S_ADDSQ,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_SQ,
    S_DIFF,
    S_DIV_MEAN,
    S_DIV_VAR,
    S_SQRT,
    S_MUL_BAND,
    S_BAND
  } state_e;

  // zero length means one, anything above the store depth saturates
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
    logic [LEN_W-1:0] n;
    if (wl == '0) begin
      n = LEN_W'(1);
    end else if (wl > LEN_W'(WIN_MAX)) begin
      n = LEN_W'(WIN_MAX);
    end else begin
      n = wl;
    end
    return n;
  endfunction

endpackage

### design/bbs_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module bbs_ram #(
  parameter int Width = 24,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/bollinger_band_signal_unit.sv
// an item that completes a window gives a result after acceptance; an item that only fills
// the window gives none, and the unit returns to idle, after which the next item is taken.
// one item is in work at a time, held longer while an earlier result waits; its work is set
// by the shared radix-4 divider (16 + 32 steps) and the bit-serial square root (32 steps).
// reset (async, active low): sums, pointer, fill count and item count clear, window length
// goes to 20 and multiplier to 2.0; the price store is not cleared and needs no sweep.
// depends on bbs_pkg and bbs_ram
module bollinger_band_signal_unit
  import bbs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [PRICE_W-1:0]        price_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_W-1:0]          sample_index_o,
  output logic [MEAN_W-1:0]         window_mean_o,
  output logic [UPPER_W-1:0]        upper_band_o,
  output logic signed [LOWER_W-1:0] lower_band_o,
  output logic [ACT_W-1:0]          action_o
);

  state_e state_q, state_d;

  // control state
  logic [LEN_W-1:0]  n_q;
  logic [MULT_W-1:0] bm_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic [PTR_W-1:0]  wp_q;
  logic [LEN_W-1:0]  fill_q;
  logic [IDX_W-1:0]  item_cnt_q;
  logic [CNT_W-1:0]  step_q;
  logic              out_valid_q;

  // item payload
  logic [PRICE_W-1:0] price_q;
  logic [IDX_W-1:0]   idx_q;
  logic               full_q;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] d_q;

  // divider and square root state
  logic [REM_W-1:0]  rem_q, div_q;
  logic [PROD_W-1:0] dq_q;
  logic [PROD_W-1:0] v_q, res_q, bit_q;
  logic [MEAN_W-1:0] mean_q;
  logic [SD_W-1:0]   sd_q;

  // output register
  logic [IDX_W-1:0]          idx_out_q;
  logic [MEAN_W-1:0]         mean_out_q;
  logic [UPPER_W-1:0]        upper_q;
  logic signed [LOWER_W-1:0] lower_q;
  logic [ACT_W-1:0]          act_q;

  // pointer handling
  logic [PTR_W-1:0]   wp_eff;
  logic [LEN_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   wp_wrap;
  logic               full_now;
  logic [PRICE_W-1:0] old_rd;
  logic               ram_we;

  // divider step, two quotient bits a cycle
  logic [REM_W:0]    t1, t2;
  logic              ge1, ge2;
  logic [REM_W-1:0]  r1, r2;
  logic [PROD_W-1:0] dq_next;

  // square root step
  logic [PROD_W-1:0] sq_t, v_next, res_next;
  logic              sq_ge;

  // band and action
  logic [BAND_W-1:0]         band;
  logic [UPPER_W-1:0]        upper_c;
  logic signed [LOWER_W-1:0] lower_c;
  logic [MEAN_W-1:0]         pp;
  action_e                   act_c;
  logic                      can_out;

  assign wp_eff   = ({1'b0, wp_q} >= n_q) ? '0 : wp_q;
  assign wp_inc   = {1'b0, wp_eff} + LEN_W'(1);
  assign wp_wrap  = (wp_inc >= n_q) ? '0 : wp_inc[PTR_W-1:0];
  assign full_now = (fill_q >= n_q);
  assign can_out  = !out_valid_q || out_ready_i;

  // price store
  bbs_ram #(
    .Width (PRICE_W),
    .Depth (WIN_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_eff),
    .wdata_i (price_q),
    .raddr_i (wp_eff),
    .rdata_o (old_rd)
  );

  // divider datapath
  always_comb begin
    t1      = {rem_q, dq_q[PROD_W-1]};
    ge1     = (t1 >= {1'b0, div_q});
    r1      = ge1 ? REM_W'(t1 - {1'b0, div_q}) : t1[REM_W-1:0];
    t2      = {r1, dq_q[PROD_W-2]};
    ge2     = (t2 >= {1'b0, div_q});
    r2      = ge2 ? REM_W'(t2 - {1'b0, div_q}) : t2[REM_W-1:0];
    dq_next = {dq_q[PROD_W-3:0], ge1, ge2};
  end

  // square root datapath
  always_comb begin
    sq_t     = res_q + bit_q;
    sq_ge    = (v_q >= sq_t);
    v_next   = sq_ge ? v_q - sq_t : v_q;
    res_next = sq_ge ? (res_q >> 1) + bit_q : (res_q >> 1);
  end

  // bands and trading decision
  always_comb begin
    band    = prod_q[BAND_W+7:8];
    upper_c = {5'd0, mean_q} + {1'b0, band};
    lower_c = $signed({6'd0, mean_q}) - $signed({2'd0, band});
    pp      = {price_q, 8'd0};
    if ({5'd0, pp} > upper_c) begin
      act_c = ACT_SELL;
    end else if ($signed({6'd0, pp}) < lower_c) begin
      act_c = ACT_BUY;
    end else begin
      act_c = ACT_HOLD;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_OLD;
      S_OLD:      state_d = S_NEWSQ;
      S_NEWSQ:    state_d = S_ADDSQ;
      S_ADDSQ:    state_d = full_now ? S_MUL_LO : S_IDLE;
      S_MUL_LO:   state_d = S_MUL_HI;
      S_MUL_HI:   state_d = S_MUL_SQ;
      S_MUL_SQ:   state_d = S_DIFF;
      S_DIFF:     state_d = S_DIV_MEAN;
      S_DIV_MEAN: if (step_q == '0) state_d = S_DIV_VAR;
      S_DIV_VAR:  if (step_q == '0) state_d = S_SQRT;
      S_SQRT:     if (step_q == '0) state_d = S_MUL_BAND;
      S_MUL_BAND: state_d = S_BAND;
      S_BAND:     if (can_out) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // state outputs and multiplier operand select
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    ram_we     = (state_q == S_OLD);
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_OLD: begin
        mul_a = MUL_W'(old_rd);
        mul_b = MUL_W'(old_rd);
      end
      S_NEWSQ: begin
        mul_a = MUL_W'(price_q);
        mul_b = MUL_W'(price_q);
      end
      S_MUL_LO: begin
        mul_a = MUL_W'(n_q);
        mul_b = MUL_W'(sq_q[Q_SPLIT-1:0]);
      end
      S_MUL_HI: begin
        mul_a = MUL_W'(n_q);
        mul_b = MUL_W'(sq_q[SQ_W-1:Q_SPLIT]);
      end
      S_MUL_SQ: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      // band product is kept while the result waits
      S_MUL_BAND, S_BAND: begin
        mul_a = MUL_W'(bm_q);
        mul_b = sd_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers, window bookkeeping and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= WIN_LEN_RST;
      bm_q        <= MULT_RST;
      sum_q       <= '0;
      sq_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      item_cnt_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) begin
        item_cnt_q <= item_cnt_q + IDX_W'(1);
      end
      case (state_q)
        S_OLD: begin
          sum_q  <= sum_q - (full_now ? SUM_W'(old_rd) : '0) + SUM_W'(price_q);
          fill_q <= full_now ? n_q : fill_q + LEN_W'(1);
          wp_q   <= wp_wrap;
        end
        S_NEWSQ: sq_q <= sq_q - (full_q ? prod_q[SQ_W-1:0] : '0);
        S_ADDSQ: sq_q <= sq_q + prod_q[SQ_W-1:0];
        S_DIFF:  step_q <= DIV_MEAN_LAST;
        S_DIV_MEAN, S_DIV_VAR: begin
          step_q <= (step_q == '0) ? DIV_VAR_LAST : step_q - CNT_W'(1);
          if (state_q == S_DIV_VAR && step_q == '0) begin
            step_q <= SQRT_LAST;
          end
        end
        S_SQRT:  step_q <= step_q - CNT_W'(1);
        default: ;
      endcase
      // output handshake
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_BAND && can_out) begin
        out_valid_q <= 1'b1;
      end
      // register writes, window length restarts the window
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIN_LEN: begin
            n_q    <= eff_len(cfg_data_i[LEN_W-1:0]);
            sum_q  <= '0;
            sq_q   <= '0;
            wp_q   <= '0;
            fill_q <= '0;
          end
          REG_BAND_MULT: bm_q <= cfg_data_i[MULT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          price_q <= price_i;
          idx_q   <= item_cnt_q;
        end
      end
      S_OLD:    full_q <= full_now;
      S_MUL_HI: acc_q <= prod_q;
      S_MUL_SQ: acc_q <= acc_q + {prod_q[PROD_W-Q_SPLIT-1:0], {Q_SPLIT{1'b0}}};
      S_DIFF: begin
        d_q   <= (acc_q > prod_q) ? acc_q - prod_q : '0;
        rem_q <= {9'd0, sum_q[SUM_W-1:PRICE_W]};
        dq_q  <= {sum_q[PRICE_W-1:0], 8'd0, 32'd0};
        div_q <= {8'd0, n_q};
      end
      S_DIV_MEAN: begin
        rem_q <= r2;
        dq_q  <= dq_next;
        if (step_q == '0) begin
          mean_q <= dq_next[MEAN_W-1:0];
          rem_q  <= {1'b0, d_q[PROD_W-1:48]};
          dq_q   <= {d_q[47:0], 16'd0};
          div_q  <= REM_W'({8'd0, n_q} * {8'd0, n_q});
        end
      end
      S_DIV_VAR: begin
        rem_q <= r2;
        dq_q  <= dq_next;
        if (step_q == '0) begin
          v_q   <= dq_next;
          res_q <= '0;
          bit_q <= SQRT_BIT0;
        end
      end
      S_SQRT: begin
        v_q   <= v_next;
        res_q <= res_next;
        bit_q <= bit_q >> 2;
        if (step_q == '0) begin
          sd_q <= res_next[SD_W-1:0];
        end
      end
      S_BAND: begin
        if (can_out) begin
          idx_out_q  <= idx_q;
          mean_out_q <= mean_q;
          upper_q    <= upper_c;
          lower_q    <= lower_c;
          act_q      <= act_c;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign sample_index_o = idx_out_q;
  assign window_mean_o  = mean_out_q;
  assign upper_band_o   = upper_q;
  assign lower_band_o   = lower_q;
  assign action_o       = act_q;

endmodule

### design/bbs_checker.sv
// port-level checks on the bollinger band signal unit, bound to the top level
// depends on bbs_pkg
module bbs_checker
  import bbs_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [CFG_W-1:0]          cfg_data_i,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [PRICE_W-1:0]        price_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [IDX_W-1:0]          sample_index_o,
  input logic [MEAN_W-1:0]         window_mean_o,
  input logic [UPPER_W-1:0]        upper_band_o,
  input logic signed [LOWER_W-1:0] lower_band_o,
  input logic [ACT_W-1:0]          action_o
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // bands sit symmetrically about the mean
  a_band_symmetry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (LOWER_W'({1'b0, upper_band_o} + lower_band_o)
                     == LOWER_W'({window_mean_o, 1'b0})))
    else $error("upper and lower band not symmetric about the mean");

  // upper band never below the mean
  a_upper_above_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (upper_band_o >= {5'd0, window_mean_o}))
    else $error("upper band below mean");

  // a new result only appears at the end of a busy spell
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised while the unit was idle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_index_o)
                                   && $stable(action_o))
    else $error("stalled result item changed or dropped");

endmodule

bind bollinger_band_signal_unit bbs_checker u_bbs_checker (.*);
